@@ sv/prrs_pkg.sv @@
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types, codes and constants of the periodic report retry sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package prrs_pkg;

    // Width of the two report period timers.
    localparam int TIMER_BITS = 32;
    // Width used to compare a timer against a 32-bit period.
    localparam int CMP_BITS   = (TIMER_BITS > 32) ? TIMER_BITS : 32;

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Configuration register reset values.
    localparam logic [31:0] SHORT_PERIOD_RST   = 32'd1800;
    localparam logic [31:0] LONG_PERIOD_RST    = 32'd86400;
    localparam logic        HEATING_SEASON_RST = 1'b1;
    localparam logic [15:0] REPLY_TIMEOUT_RST  = 16'd100;
    localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd3;
    localparam logic [15:0] TRIGGER_LEAD_RST   = 16'd15;
    localparam logic [15:0] START_LEAD_RST     = 16'd9;

    // APB address width: seven registers at word spacing.
    localparam int ADDR_BITS = 5;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        CFG_SHORT_PERIOD   = 3'd0,
        CFG_LONG_PERIOD    = 3'd1,
        CFG_HEATING_SEASON = 3'd2,
        CFG_REPLY_TIMEOUT  = 3'd3,
        CFG_RETRY_LIMIT    = 3'd4,
        CFG_TRIGGER_LEAD   = 3'd5,
        CFG_START_LEAD     = 3'd6
    } cfg_idx_t;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_READY   = 3'd1,
        PH_PACKAGE = 3'd2,
        PH_SEND    = 3'd3,
        PH_RECV    = 3'd4,
        PH_CHECK   = 3'd5,
        PH_SUCCESS = 3'd6,
        PH_FINISH  = 3'd7
    } phase_t;

    // Antenna status codes.
    typedef enum logic [1:0] {
        LINK_UNCHANGED  = 2'd0,
        LINK_CONNECTING = 2'd1,
        LINK_CONNECTED  = 2'd2,
        LINK_NO_SIGNAL  = 2'd3
    } link_t;

    // Configuration bundle.
    typedef struct packed {
        logic [31:0] short_period;
        logic [31:0] long_period;
        logic        heating_season;
        logic [15:0] reply_timeout;
        logic [7:0]  retry_limit;
        logic [15:0] trigger_lead;
        logic [15:0] start_lead;
    } cfg_t;

    // One input item.
    typedef struct packed {
        logic op;
        logic address_unset;
        logic radio_init_ok;
        logic frame_received;
        logic frame_valid;
        logic reply_accepted;
        logic logged_in;
    } item_t;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic       send_active;
        logic       radio_shutdown;
        logic       mark_logged_in;
        logic       save_settings;
        logic       count_success;
        logic       count_attempt;
        link_t      link_status;
        logic       send_frame;
        logic       build_report;
        logic       radio_power_up;
        phase_t     phase;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

    // Period minus lead, saturating at zero, cut to the timer width.
    function automatic timer_t lead_sub(input logic [31:0] period,
                                        input logic [15:0] lead);
        logic [CMP_BITS-1:0] diff;
        diff = CMP_BITS'(period) - CMP_BITS'(lead);
        if (period > 32'(lead)) begin
            return TIMER_BITS'(diff);
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

@@ sv/prrs_cfg.sv @@
// ----------------------------------------------------------------------------
// prrs_cfg
// APB register file holding the sequencer configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_cfg import prrs_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access phase of a write transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_period   <= SHORT_PERIOD_RST;
            cfg_reg.long_period    <= LONG_PERIOD_RST;
            cfg_reg.heating_season <= HEATING_SEASON_RST;
            cfg_reg.reply_timeout  <= REPLY_TIMEOUT_RST;
            cfg_reg.retry_limit    <= RETRY_LIMIT_RST;
            cfg_reg.trigger_lead   <= TRIGGER_LEAD_RST;
            cfg_reg.start_lead     <= START_LEAD_RST;
        end else if (wr_en) begin
            case (idx)
                CFG_SHORT_PERIOD:   cfg_reg.short_period   <= pwdata;
                CFG_LONG_PERIOD:    cfg_reg.long_period    <= pwdata;
                CFG_HEATING_SEASON: cfg_reg.heating_season <= pwdata[0];
                CFG_REPLY_TIMEOUT:  cfg_reg.reply_timeout  <= pwdata[15:0];
                CFG_RETRY_LIMIT:    cfg_reg.retry_limit    <= pwdata[7:0];
                CFG_TRIGGER_LEAD:   cfg_reg.trigger_lead   <= pwdata[15:0];
                CFG_START_LEAD:     cfg_reg.start_lead     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (idx)
            CFG_SHORT_PERIOD:   prdata = cfg_reg.short_period;
            CFG_LONG_PERIOD:    prdata = cfg_reg.long_period;
            CFG_HEATING_SEASON: prdata = {31'd0, cfg_reg.heating_season};
            CFG_REPLY_TIMEOUT:  prdata = {16'd0, cfg_reg.reply_timeout};
            CFG_RETRY_LIMIT:    prdata = {24'd0, cfg_reg.retry_limit};
            CFG_TRIGGER_LEAD:   prdata = {16'd0, cfg_reg.trigger_lead};
            CFG_START_LEAD:     prdata = {16'd0, cfg_reg.start_lead};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/prrs_seq.sv @@
// ----------------------------------------------------------------------------
// prrs_seq
// Sequencer state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module prrs_seq import prrs_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  retry_count_reg, retry_count_next;
    logic [15:0] wait_count_reg, wait_count_next;
    timer_t      short_timer_reg, short_timer_next;
    timer_t      long_timer_reg, long_timer_next;
    logic        send_flag_reg, send_flag_next;
    logic        retry_req, trigger_req;
    timer_t      short_inc, long_inc;
    logic [15:0] wait_dec;

    assign short_inc = short_timer_reg + 1'b1;
    assign long_inc  = long_timer_reg + 1'b1;
    assign wait_dec  = wait_count_reg - 1'b1;

    // State registers, updated once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            retry_count_reg <= '0;
            wait_count_reg  <= '0;
            short_timer_reg <= lead_sub(SHORT_PERIOD_RST, START_LEAD_RST);
            long_timer_reg  <= lead_sub(LONG_PERIOD_RST, START_LEAD_RST);
            send_flag_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            retry_count_reg <= retry_count_next;
            wait_count_reg  <= wait_count_next;
            short_timer_reg <= short_timer_next;
            long_timer_reg  <= long_timer_next;
            send_flag_reg   <= send_flag_next;
        end
    end

    // Next state and result for the item in the input register.
    always_comb begin
        phase_next       = phase_reg;
        retry_count_next = retry_count_reg;
        wait_count_next  = wait_count_reg;
        short_timer_next = short_timer_reg;
        long_timer_next  = long_timer_reg;
        send_flag_next   = send_flag_reg;
        retry_req        = 1'b0;
        trigger_req      = 1'b0;
        result           = '0;

        if (item.op) begin
            trigger_req = 1'b1;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    // Count toward the period of the current season mode.
                    if (cfg.heating_season) begin
                        short_timer_next = short_inc;
                        if (CMP_BITS'(short_inc) >= CMP_BITS'(cfg.short_period)) begin
                            phase_next       = PH_READY;
                            short_timer_next = '0;
                        end
                    end else begin
                        long_timer_next = long_inc;
                        if (CMP_BITS'(long_inc) >= CMP_BITS'(cfg.long_period)) begin
                            phase_next      = PH_READY;
                            long_timer_next = '0;
                        end
                    end
                end
                PH_READY: begin
                    if (item.address_unset) begin
                        result.radio_power_up = 1'b1;
                        phase_next = item.radio_init_ok ? PH_PACKAGE : PH_IDLE;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PACKAGE: begin
                    result.count_attempt = 1'b1;
                    result.build_report  = 1'b1;
                    phase_next           = PH_SEND;
                end
                PH_SEND: begin
                    send_flag_next     = 1'b1;
                    result.link_status = LINK_CONNECTING;
                    result.send_frame  = 1'b1;
                    wait_count_next    = cfg.reply_timeout;
                    phase_next         = PH_RECV;
                end
                PH_RECV: begin
                    // A zero countdown never expires.
                    if (item.frame_received) begin
                        phase_next = PH_CHECK;
                    end else if (wait_count_reg != 16'd0) begin
                        wait_count_next = wait_dec;
                        retry_req       = (wait_dec == 16'd0);
                    end
                end
                PH_CHECK: begin
                    if (item.frame_valid && item.reply_accepted) begin
                        phase_next = PH_SUCCESS;
                    end else begin
                        retry_req = 1'b1;
                    end
                end
                PH_SUCCESS: begin
                    result.link_status   = LINK_CONNECTED;
                    result.save_settings = 1'b1;
                    if (item.logged_in) begin
                        result.count_success = 1'b1;
                        phase_next           = PH_FINISH;
                    end else begin
                        result.mark_logged_in = 1'b1;
                        trigger_req           = 1'b1;
                    end
                end
                PH_FINISH: begin
                    send_flag_next        = 1'b0;
                    result.radio_shutdown = 1'b1;
                    phase_next            = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Resend while retries remain, else give up with no signal.
        if (retry_req) begin
            if (retry_count_reg < cfg.retry_limit) begin
                retry_count_next = retry_count_reg + 1'b1;
                phase_next       = PH_SEND;
            end else begin
                result.link_status = LINK_NO_SIGNAL;
                phase_next         = PH_FINISH;
            end
        end

        // A trigger restarts the cycle and reloads both period timers.
        if (trigger_req) begin
            phase_next       = PH_READY;
            retry_count_next = '0;
            short_timer_next = lead_sub(cfg.short_period, cfg.trigger_lead);
            long_timer_next  = lead_sub(cfg.long_period, cfg.trigger_lead);
        end

        result.phase       = phase_next;
        result.send_active = send_flag_next;
    end

    // A trigger always lands in the ready phase with a cleared retry count.
    a_trigger_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op |=> phase_reg == PH_READY && retry_count_reg == 8'd0)
        else $error("trigger did not restart the cycle");

    // State only moves when an item is processed.
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(phase_reg) && $stable(wait_count_reg)
                  && $stable(send_flag_reg))
        else $error("sequencer state changed without an item");

    // At most one radio action strobe per result.
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> $onehot0({result.radio_power_up, result.build_report,
                           result.send_frame, result.radio_shutdown}))
        else $error("several radio actions in one result");

    // Sending raises the send flag and starts the reply countdown.
    a_send_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.op && phase_reg == PH_SEND
        |=> send_flag_reg && phase_reg == PH_RECV)
        else $error("send did not arm the reply wait");

endmodule

`default_nettype wire

@@ sv/periodic_report_retry_sequencer.sv @@
// Path: an accepted item waits in the input register; when it is processed, its result
// loads into the result register, which drives the result stream.
// Throughput: one item per cycle while m_tready stays high; a held result only
// stalls the input once both the input and the result register are full.
// Reset: aresetn low clears both valid flags, puts the sequencer in idle, loads
// the configuration defaults and sets each period timer to period minus start lead.
// ----------------------------------------------------------------------------
// periodic_report_retry_sequencer
// Periodic radio report sequencer with reply timeout and bounded retries.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_report_retry_sequencer import prrs_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // address_unset, radio_init_ok, frame_received, frame_valid,
    // reply_accepted, logged_in, 2 bits zero
    input  wire logic [7:0]           s_tdata,
    // op
    input  wire logic                 s_tuser,
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // phase[2:0], radio_power_up, build_report, send_frame, link_status[1:0],
    // count_attempt, count_success, save_settings, mark_logged_in,
    // radio_shutdown, send_active, 2 bits zero
    output logic [15:0]               m_tdata,
    // Configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t step_result;
    cfg_t    cfg;
    logic    fire;
    logic    s_take;

    // Process the held item when the result register is free or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(16 - RESULT_BITS)'(0), out_result_reg};

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.op             <= s_tuser;
            in_item_reg.address_unset  <= s_tdata[0];
            in_item_reg.radio_init_ok  <= s_tdata[1];
            in_item_reg.frame_received <= s_tdata[2];
            in_item_reg.frame_valid    <= s_tdata[3];
            in_item_reg.reply_accepted <= s_tdata[4];
            in_item_reg.logged_in      <= s_tdata[5];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= step_result;
        end
    end

    prrs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prrs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

endmodule

`default_nettype wire
